@@ hdl/pcf_pkg.sv @@
// Shared types and constants of the PCF compression function block.
package pcf_pkg;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_OBSERVE_WINDOW = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CALC_OVERHEAD  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FAULT_TOL      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TX_DELAY   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STATIC_DELAY   = 3'd4;

    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned TIME_W     = 64;
    localparam int unsigned OFFSET_W   = 32;
    localparam int unsigned FRAMES_W   = 4;
    localparam int unsigned TC_FRAC_W  = 16;

    // Controller to datapath commands
    typedef struct packed {
        logic load;       // capture the input beat
        logic calc_clk;   // corrected clock
        logic calc_diff;  // delay minus clock, offset
        logic calc_perm;  // permanence time
        logic insert;     // sorted insert into the store
        logic cmp_gaps;   // gaps to earliest, single-frame product
        logic cmp_count;  // number of kept gaps, single-frame sum
        logic cmp_pick;   // select gaps for the average
        logic finish;     // load result registers, empty the window
    } pcf_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic full;
    } pcf_sts_t;

endpackage

@@ hdl/pcf_ctrl.sv @@
// Controller state machine of the PCF compression function block.
module pcf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              frame_present,
    input  logic              window_end,
    input  pcf_pkg::pcf_sts_t sts,
    output pcf_pkg::pcf_cmd_t cmd,
    output logic              busy
);
    import pcf_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_CLK  = 4'd1;
    localparam logic [3:0] ST_DIFF = 4'd2;
    localparam logic [3:0] ST_PERM = 4'd3;
    localparam logic [3:0] ST_INS  = 4'd4;
    localparam logic [3:0] ST_GAP  = 4'd5;
    localparam logic [3:0] ST_CNT  = 4'd6;
    localparam logic [3:0] ST_PICK = 4'd7;
    localparam logic [3:0] ST_FIN  = 4'd8;

    logic [3:0] state_reg, state_next;
    logic       close_reg, close_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            close_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            close_reg <= close_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        close_next = close_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    close_next = window_end;
                    // a frame into a full window is dropped
                    if (frame_present && !sts.full)
                        state_next = ST_CLK;
                    else if (window_end)
                        state_next = ST_GAP;
                end
            end
            ST_CLK:
            begin
                cmd.calc_clk = 1'b1;
                state_next   = ST_DIFF;
            end
            ST_DIFF:
            begin
                cmd.calc_diff = 1'b1;
                state_next    = ST_PERM;
            end
            ST_PERM:
            begin
                cmd.calc_perm = 1'b1;
                state_next    = ST_INS;
            end
            ST_INS:
            begin
                cmd.insert = 1'b1;
                state_next = close_reg ? ST_GAP : ST_IDLE;
            end
            ST_GAP:
            begin
                cmd.cmp_gaps = 1'b1;
                state_next   = ST_CNT;
            end
            ST_CNT:
            begin
                cmd.cmp_count = 1'b1;
                state_next    = ST_PICK;
            end
            ST_PICK:
            begin
                cmd.cmp_pick = 1'b1;
                state_next   = ST_FIN;
            end
            ST_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

@@ hdl/pcf_datapath.sv @@
// Datapath of the PCF compression function: config, sorted store, average.
module pcf_datapath #(
    parameter int WINDOW_DEPTH = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [pcf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pcf_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic [pcf_pkg::TIME_W-1:0]          receive_time,
    input  logic [pcf_pkg::TIME_W-1:0]          transparent_clock_raw,
    input  pcf_pkg::pcf_cmd_t                   cmd,
    output pcf_pkg::pcf_sts_t                   sts,
    output logic                                done,
    output logic [pcf_pkg::TIME_W-1:0]          correction,
    output logic signed [pcf_pkg::OFFSET_W-1:0] clock_offset,
    output logic                                offset_valid,
    output logic [pcf_pkg::FRAMES_W-1:0]        frames_in_window
);
    import pcf_pkg::*;

    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    // fixed store taps for the gaps; clamped for shallow windows
    localparam int G2 = (2 < WINDOW_DEPTH) ? 2 : WINDOW_DEPTH - 1;
    localparam int G3 = (3 < WINDOW_DEPTH) ? 3 : WINDOW_DEPTH - 1;
    localparam int G4 = (4 < WINDOW_DEPTH) ? 4 : WINDOW_DEPTH - 1;

    // configuration
    logic [CFG_DATA_W-1:0] observe_window_reg;
    logic [CFG_DATA_W-1:0] calc_overhead_reg;
    logic [1:0]            fault_tol_reg;
    logic [CFG_DATA_W-1:0] max_tx_delay_reg;
    logic [CFG_DATA_W-1:0] static_delay_reg;

    // frame arithmetic
    logic [TIME_W-1:0]   rx_reg, tc_reg, clk_reg, diff_reg, perm_reg;
    logic [OFFSET_W-1:0] off_reg;

    // window state
    logic [TIME_W-1:0]   store_reg [WINDOW_DEPTH];
    logic [WINDOW_DEPTH-1:0] ge;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [OFFSET_W-1:0] chosen_reg;

    // compression
    logic [WINDOW_DEPTH-1:0] ok_reg;
    logic [TIME_W-1:0]   g1_reg, g2_reg, g3_reg, g4_reg;
    logic [CNT_W-1:0]    k_reg, k_next;
    logic [CFG_DATA_W+2:0] mult_reg;
    logic [CFG_DATA_W+3:0] one_reg;
    logic [TIME_W:0]     pick_reg;
    logic                halve_reg;
    logic [TIME_W-1:0]   avg;
    logic [TIME_W-1:0]   corr_next;

    logic                done_reg;
    logic [TIME_W-1:0]   corr_reg;
    logic [OFFSET_W-1:0] offs_reg;
    logic                valid_reg;
    logic [FRAMES_W-1:0] frames_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            observe_window_reg <= '0;
            calc_overhead_reg  <= '0;
            fault_tol_reg      <= 2'd1;
            max_tx_delay_reg   <= '0;
            static_delay_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_OBSERVE_WINDOW: observe_window_reg <= cfg_wdata;
                REG_CALC_OVERHEAD:  calc_overhead_reg  <= cfg_wdata;
                REG_FAULT_TOL:      fault_tol_reg      <= cfg_wdata[1:0];
                REG_MAX_TX_DELAY:   max_tx_delay_reg   <= cfg_wdata;
                REG_STATIC_DELAY:   static_delay_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Per-frame arithmetic, one add per step (two in the difference step)
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rx_reg <= receive_time;
            tc_reg <= transparent_clock_raw;
        end
        if (cmd.calc_clk)
            clk_reg <= (tc_reg >> TC_FRAC_W) + TIME_W'(static_delay_reg);
        if (cmd.calc_diff)
        begin
            diff_reg <= TIME_W'(max_tx_delay_reg) - clk_reg;
            off_reg  <= clk_reg[OFFSET_W-1:0] - rx_reg[OFFSET_W-1:0];
        end
        if (cmd.calc_perm)
            perm_reg <= rx_reg + diff_reg;
    end

    // Insert position: entries at or past the count, or above the new time
    always_comb
    begin
        for (int i = 0; i < WINDOW_DEPTH; i++)
            ge[i] = (int'(cnt_reg) <= i) || (store_reg[i] > perm_reg);
    end

    // Sorted store: each cell keeps, takes the new time, or takes its lower neighbor
    for (genvar g = 0; g < WINDOW_DEPTH; g++)
    begin : g_cell
        if (g == 0)
        begin : g_first
            always_ff @(posedge clk)
            begin
                if (cmd.insert && ge[0])
                    store_reg[0] <= perm_reg;
            end
        end
        else
        begin : g_rest
            always_ff @(posedge clk)
            begin
                if (cmd.insert && ge[g])
                    store_reg[g] <= ge[g-1] ? store_reg[g-1] : perm_reg;
            end
        end
    end

    // Frame count and chosen offset
    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.finish)
            cnt_next = '0;
        else if (cmd.insert)
            cnt_next = CNT_W'(cnt_reg + 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            chosen_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (cmd.finish)
                chosen_reg <= '0;
            else if (cmd.insert && (int'(cnt_reg) < 3))
                chosen_reg <= off_reg;
        end
    end

    assign sts.full = (int'(cnt_reg) == WINDOW_DEPTH);

    // Number of kept gaps (kept gaps form a prefix of the sorted store)
    always_comb
    begin
        k_next = '0;
        for (int i = 0; i < WINDOW_DEPTH; i++)
            k_next = CNT_W'(k_next + CNT_W'(ok_reg[i]));
    end

    // Pick the averaged value, or the single-frame sum when the window holds one frame
    always_comb
    begin
        corr_next = '0;
        avg       = halve_reg ? pick_reg[TIME_W:1] : pick_reg[TIME_W-1:0];
        if (cnt_reg == CNT_W'(1))
            corr_next = TIME_W'(one_reg);
        else if (cnt_reg != '0)
            corr_next = avg;
    end

    // Compression steps
    always_ff @(posedge clk)
    begin
        if (cmd.cmp_gaps)
        begin
            ok_reg[0] <= 1'b0;
            for (int i = 1; i < WINDOW_DEPTH; i++)
                ok_reg[i] <= (int'(cnt_reg) > i) &&
                             ((store_reg[i] - store_reg[0]) <= TIME_W'(observe_window_reg));
            g1_reg   <= store_reg[1]  - store_reg[0];
            g2_reg   <= store_reg[G2] - store_reg[0];
            g3_reg   <= store_reg[G3] - store_reg[0];
            g4_reg   <= store_reg[G4] - store_reg[0];
            mult_reg <= (CFG_DATA_W+3)'({1'b0, fault_tol_reg} + 3'd1)
                        * (CFG_DATA_W+3)'(observe_window_reg);
        end
        if (cmd.cmp_count)
        begin
            k_reg   <= k_next;
            one_reg <= (CFG_DATA_W+4)'(mult_reg) + (CFG_DATA_W+4)'(calc_overhead_reg);
        end
        if (cmd.cmp_pick)
        begin
            halve_reg <= 1'b0;
            priority if (k_reg == CNT_W'(0))
                pick_reg <= '0;
            else if (k_reg == CNT_W'(1))
                pick_reg <= (TIME_W+1)'(g1_reg);
            else if (k_reg == CNT_W'(2))
            begin
                pick_reg  <= (TIME_W+1)'(g1_reg) + (TIME_W+1)'(g2_reg);
                halve_reg <= 1'b1;
            end
            else if (k_reg == CNT_W'(3))
                pick_reg <= (TIME_W+1)'(g2_reg);
            else if (k_reg == CNT_W'(4))
            begin
                pick_reg  <= (TIME_W+1)'(g2_reg) + (TIME_W+1)'(g3_reg);
                halve_reg <= 1'b1;
            end
            else
            begin
                pick_reg  <= (TIME_W+1)'(g2_reg) + (TIME_W+1)'(g4_reg);
                halve_reg <= 1'b1;
            end
        end
    end

    // Result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= cmd.finish;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            corr_reg   <= corr_next;
            offs_reg   <= chosen_reg;
            valid_reg  <= (cnt_reg != '0);
            frames_reg <= FRAMES_W'(cnt_reg);
        end
    end

    assign done             = done_reg;
    assign correction       = corr_reg;
    assign clock_offset     = offs_reg;
    assign offset_valid     = valid_reg;
    assign frames_in_window = frames_reg;

endmodule

@@ hdl/pcf_compression_function_core.sv @@
// Top level of the PCF compression function: controller plus datapath.
// A stored frame keeps busy high through the clock, difference, permanence and insert states after start.
// A closing beat adds the gaps, count, pick and finish states; done pulses in the cycle after finish.
// A frame into a full window is dropped and adds none of the frame states.
// The result is held on the ports until the next finish; done is high for one cycle; the receiver cannot stall.
// Reset (rst_n low, asynchronous) empties the window and loads register defaults.
module pcf_compression_function_core #(
    parameter int WINDOW_DEPTH = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                cfg_we,
    input  logic [pcf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pcf_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic [pcf_pkg::TIME_W-1:0]          receive_time,
    input  logic [pcf_pkg::TIME_W-1:0]          transparent_clock_raw,
    input  logic                                frame_present,
    input  logic                                window_end,
    output logic                                done,
    output logic [pcf_pkg::TIME_W-1:0]          correction,
    output logic signed [pcf_pkg::OFFSET_W-1:0] clock_offset,
    output logic                                offset_valid,
    output logic [pcf_pkg::FRAMES_W-1:0]        frames_in_window
);
    import pcf_pkg::*;

    pcf_cmd_t cmd;
    pcf_sts_t sts;

    pcf_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .frame_present (frame_present),
        .window_end    (window_end),
        .sts           (sts),
        .cmd           (cmd),
        .busy          (busy)
    );

    pcf_datapath #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_datapath (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .cfg_we                (cfg_we),
        .cfg_index             (cfg_index),
        .cfg_wdata             (cfg_wdata),
        .receive_time          (receive_time),
        .transparent_clock_raw (transparent_clock_raw),
        .cmd                   (cmd),
        .sts                   (sts),
        .done                  (done),
        .correction            (correction),
        .clock_offset          (clock_offset),
        .offset_valid          (offset_valid),
        .frames_in_window      (frames_in_window)
    );

    // A result beat always follows a busy cycle
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result beat without preceding work");

    // A close-only beat gives its result after the gaps, count, pick and finish states
    a_close_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !frame_present && window_end) |-> ##5 done)
        else $error("close-only beat result missing");

    // An empty window reports zero correction and offset
    a_empty_window: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !offset_valid) |-> (correction == '0 && clock_offset == '0))
        else $error("empty window result not zero");

endmodule
